/* design/tsd_pkg.sv */
// ----------------------------------------------------------------------------
// tsd_pkg: shared types and codes of the shootdown tracker
// Item layouts, opcode and status codes, register indexes and the
// update/read bundles between the engine and the per-CPU table.
// ----------------------------------------------------------------------------
`default_nettype none

package tsd_pkg;

   // opcodes of an input item
   localparam logic [2:0] OP_START     = 3'd0;
   localparam logic [2:0] OP_IRQ_ACK   = 3'd1;
   localparam logic [2:0] OP_POLL_ACK  = 3'd2;
   localparam logic [2:0] OP_TICK      = 3'd3;
   localparam logic [2:0] OP_SET_ONLINE = 3'd4;
   localparam logic [2:0] OP_READ_CNT  = 3'd5;

   // status codes of a result item
   localparam logic [2:0] ST_NOTHING   = 3'd0;
   localparam logic [2:0] ST_STARTED   = 3'd1;
   localparam logic [2:0] ST_BUSY      = 3'd2;
   localparam logic [2:0] ST_COMPLETED = 3'd3;
   localparam logic [2:0] ST_TIMEOUT   = 3'd4;
   localparam logic [2:0] ST_ACKED     = 3'd5;

   // configuration registers
   localparam int unsigned CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_TICKS   = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POLL_SUPPRESSED = 4'd1;
   localparam logic [31:0] TIMEOUT_RESET = 32'd2000000;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [2:0]  cpu;
      logic [63:0] address;
      logic        online_flag;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  ipi_mask;
      logic        invalidate_valid;
      logic [63:0] invalidate_address;
      logic [31:0] generation_out;
      logic [2:0]  lagging_cpu;
      logic [31:0] polled_count;
      logic [31:0] handled_count;
      logic [31:0] completed_count;
   } rsp_type;

   // engine to per-CPU table: what to change for one cpu
   typedef struct packed {
      logic [2:0] cpu;
      logic       ack_en;
      logic       inc_polled;
      logic       inc_handled;
   } tbl_upd_type;

   // per-CPU table to engine: entries of that cpu
   typedef struct packed {
      logic [31:0] acked;
      logic [31:0] polled;
      logic [31:0] handled;
   } tbl_rd_type;

endpackage

`default_nettype wire

/* design/tlb_shootdown_tracker_core.sv */
// ----------------------------------------------------------------------------
// tlb_shootdown_tracker_core: page-invalidation shootdown coordinator
// Input register, single-pass step engine with per-CPU table, result register
// and configuration registers.
// ----------------------------------------------------------------------------
// The block takes one item per cycle while rsp_ready stays high and gives
// one result item for each: start, interrupt ack, polled ack, tick, set
// online and read counters. An item is held in the input register, where
// the step engine works it out in a single pass (per-CPU generation
// compares run side by side), and then sits in the result register;
// throughput is one item per cycle as long as rsp_ready stays high. Results
// leave in order. Configuration writes (timeout in ticks, polled-ack
// suppression) are always taken at once and are meant for idle periods.
`default_nettype none

module tlb_shootdown_tracker_core #(
   parameter int NUM_CPUS = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire tsd_pkg::req_type                    req_item,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output tsd_pkg::rsp_type                         rsp_item,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [tsd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [31:0]                         csr_data
);
   import tsd_pkg::*;

   logic        req_valid_ff;
   req_type     req_item_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_item_ff;
   logic        fire;
   logic [31:0] timeout_ff;
   logic        poll_sup_ff;

   rsp_type             step_rsp;
   tbl_upd_type         tbl_upd;
   tbl_rd_type          tbl_rd;
   logic [NUM_CPUS-1:0] match_vec;
   logic [31:0]         cur_gen;

   // step when the result register is free or being emptied
   assign fire      = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || fire;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;
   assign csr_ready = 1'b1;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_item_ff <= req_item;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_item_ff <= step_rsp;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff  <= TIMEOUT_RESET;
         poll_sup_ff <= 1'b0;
      end else if (csr_valid) begin
         if (csr_index == CSR_TIMEOUT_TICKS) begin
            timeout_ff <= csr_data;
         end
         if (csr_index == CSR_POLL_SUPPRESSED) begin
            poll_sup_ff <= csr_data[0];
         end
      end
   end

   tsd_engine #(
      .NUM_CPUS(NUM_CPUS)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .fire           (fire),
      .item           (req_item_ff),
      .timeout_ticks  (timeout_ff),
      .poll_suppressed(poll_sup_ff),
      .tbl_rd         (tbl_rd),
      .match_vec      (match_vec),
      .tbl_upd        (tbl_upd),
      .cur_gen        (cur_gen),
      .rsp            (step_rsp)
   );

   tsd_cpu_table #(
      .NUM_CPUS(NUM_CPUS)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .cur_gen  (cur_gen),
      .rd_cpu   (req_item_ff.cpu),
      .upd      (tbl_upd),
      .rd       (tbl_rd),
      .match_vec(match_vec)
   );

endmodule

`default_nettype wire

/* design/tsd_cpu_table.sv */
// ----------------------------------------------------------------------------
// tsd_cpu_table: per-CPU acknowledge generations and counters
// Holds one acked generation, one polled and one handled counter per CPU,
// reads the entries of one cpu and flags every CPU that holds the current
// generation.
// ----------------------------------------------------------------------------
`default_nettype none

module tsd_cpu_table #(
   parameter int NUM_CPUS = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [31:0]          cur_gen,
   input  wire logic [2:0]           rd_cpu,
   input  wire tsd_pkg::tbl_upd_type upd,
   output tsd_pkg::tbl_rd_type       rd,
   output logic [NUM_CPUS-1:0]       match_vec
);
   import tsd_pkg::*;

   localparam int IDX_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

   logic [31:0] acked_ff   [NUM_CPUS];
   logic [31:0] polled_ff  [NUM_CPUS];
   logic [31:0] handled_ff [NUM_CPUS];

   logic [IDX_W+2:0] cpu_ext;
   logic [IDX_W-1:0] idx;
   logic             idx_ok;
   logic [IDX_W+2:0] rd_ext;
   logic [IDX_W-1:0] rd_idx;
   logic             rd_ok;

   // cpu index narrowed to the table depth
   assign cpu_ext = {{IDX_W{1'b0}}, upd.cpu};
   assign idx     = cpu_ext[IDX_W-1:0];
   assign idx_ok  = 32'(upd.cpu) < NUM_CPUS;

   // read index of the item in the input register
   assign rd_ext  = {{IDX_W{1'b0}}, rd_cpu};
   assign rd_idx  = rd_ext[IDX_W-1:0];
   assign rd_ok   = 32'(rd_cpu) < NUM_CPUS;

   // read port of the acting cpu
   always_comb begin
      rd = '0;
      if (rd_ok) begin
         rd.acked   = acked_ff[rd_idx];
         rd.polled  = polled_ff[rd_idx];
         rd.handled = handled_ff[rd_idx];
      end
   end

   // which cpus hold the current generation
   always_comb begin
      for (int i = 0; i < NUM_CPUS; i++) begin
         match_vec[i] = acked_ff[i] == cur_gen;
      end
   end

   // updates of the acting cpu
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CPUS; i++) begin
            acked_ff[i]   <= '0;
            polled_ff[i]  <= '0;
            handled_ff[i] <= '0;
         end
      end else if (idx_ok) begin
         if (upd.ack_en) begin
            acked_ff[idx] <= cur_gen;
         end
         if (upd.inc_polled) begin
            polled_ff[idx] <= polled_ff[idx] + 32'd1;
         end
         if (upd.inc_handled) begin
            handled_ff[idx] <= handled_ff[idx] + 32'd1;
         end
      end
   end

endmodule

`default_nettype wire

/* design/tsd_engine.sv */
// ----------------------------------------------------------------------------
// tsd_engine: request state and single-pass step logic
// Holds generation, address, busy state, initiator, tick count, online mask
// and completion total, and works out one result item per step.
// ----------------------------------------------------------------------------
`default_nettype none

module tsd_engine #(
   parameter int NUM_CPUS = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 fire,
   input  wire tsd_pkg::req_type     item,
   input  wire logic [31:0]          timeout_ticks,
   input  wire logic                 poll_suppressed,
   input  wire tsd_pkg::tbl_rd_type  tbl_rd,
   input  wire logic [NUM_CPUS-1:0]  match_vec,
   output tsd_pkg::tbl_upd_type      tbl_upd,
   output logic [31:0]               cur_gen,
   output tsd_pkg::rsp_type          rsp
);
   import tsd_pkg::*;

   localparam int MASK_W = (NUM_CPUS > 8) ? NUM_CPUS : 8;

   logic [31:0]         gen_ff, gen_in;
   logic [63:0]         addr_ff, addr_in;
   logic                in_flight_ff, in_flight_in;
   logic                busy_ff, busy_in;
   logic [2:0]          init_ff, init_in;
   logic [31:0]         elapsed_ff, elapsed_in;
   logic [NUM_CPUS-1:0] online_ff, online_in;
   logic [31:0]         completed_ff, completed_in;

   logic                cpu_ok;
   logic [31:0]         gen_plus;
   logic [31:0]         ack_diff;
   logic                ack_adv;
   logic [31:0]         elapsed_inc;
   logic [NUM_CPUS-1:0] lag_vec;
   logic [NUM_CPUS-1:0] lag_ack;
   logic [MASK_W-1:0]   start_tgt;
   logic [2:0]          lag_first;
   logic                poll_block;
   tbl_upd_type         upd;

   assign cur_gen  = gen_ff;
   assign cpu_ok   = 32'(item.cpu) < NUM_CPUS;
   assign gen_plus = gen_ff + 32'd1;

   // serial compare: ack moves only forward
   assign ack_diff = gen_ff - tbl_rd.acked;
   assign ack_adv  = (ack_diff != 32'd0) && !ack_diff[31];

   // saturating tick count
   assign elapsed_inc = (elapsed_ff == 32'hFFFF_FFFF) ? elapsed_ff : elapsed_ff + 32'd1;

   // targets still lagging, now and after this ack
   always_comb begin
      lag_vec   = '0;
      lag_ack   = '0;
      start_tgt = '0;
      for (int i = 0; i < NUM_CPUS; i++) begin
         lag_vec[i]   = online_ff[i] && (32'(i) != 32'(init_ff)) && !match_vec[i];
         lag_ack[i]   = lag_vec[i] && !(cpu_ok && ack_adv && (32'(i) == 32'(item.cpu)));
         start_tgt[i] = online_ff[i] && (32'(i) != 32'(item.cpu));
      end
   end

   // lowest lagging cpu
   always_comb begin
      lag_first = '0;
      for (int i = NUM_CPUS - 1; i >= 0; i--) begin
         if (lag_vec[i]) begin
            lag_first = 3'(i);
         end
      end
   end

   assign poll_block = !in_flight_ff || poll_suppressed || !cpu_ok ||
                       (gen_ff == 32'd0) || (tbl_rd.acked == gen_ff);

   // step logic
   always_comb begin
      gen_in       = gen_ff;
      addr_in      = addr_ff;
      in_flight_in = in_flight_ff;
      busy_in      = busy_ff;
      init_in      = init_ff;
      elapsed_in   = elapsed_ff;
      online_in    = online_ff;
      completed_in = completed_ff;
      rsp          = '0;
      upd          = '0;
      upd.cpu      = item.cpu;

      unique case (item.opcode)
         OP_START: begin
            if (busy_ff) begin
               rsp.status = ST_BUSY;
            end else begin
               in_flight_in           = 1'b1;
               busy_in                = 1'b1;
               gen_in                 = (gen_plus == 32'd0) ? 32'd1 : gen_plus;
               addr_in                = item.address;
               init_in                = item.cpu;
               elapsed_in             = '0;
               rsp.ipi_mask           = start_tgt[7:0];
               rsp.invalidate_valid   = 1'b1;
               rsp.invalidate_address = item.address;
               rsp.status             = ST_STARTED;
            end
         end
         OP_IRQ_ACK, OP_POLL_ACK: begin
            if (!(item.opcode == OP_POLL_ACK && poll_block)) begin
               rsp.invalidate_valid   = 1'b1;
               rsp.invalidate_address = addr_ff;
               rsp.status             = ST_ACKED;
               if (cpu_ok) begin
                  upd.ack_en      = ack_adv;
                  upd.inc_handled = item.opcode == OP_IRQ_ACK;
                  upd.inc_polled  = item.opcode == OP_POLL_ACK;
                  if (busy_ff && (lag_ack == '0)) begin
                     in_flight_in = 1'b0;
                     busy_in      = 1'b0;
                     completed_in = completed_ff + 32'd1;
                     rsp.status   = ST_COMPLETED;
                  end
               end
            end
         end
         OP_TICK: begin
            if (busy_ff) begin
               if (lag_vec == '0) begin
                  in_flight_in = 1'b0;
                  busy_in      = 1'b0;
                  completed_in = completed_ff + 32'd1;
                  rsp.status   = ST_COMPLETED;
               end else begin
                  elapsed_in = elapsed_inc;
                  if (elapsed_inc >= timeout_ticks) begin
                     in_flight_in    = 1'b0;
                     busy_in         = 1'b0;
                     rsp.status      = ST_TIMEOUT;
                     rsp.lagging_cpu = lag_first;
                  end
               end
            end
         end
         OP_SET_ONLINE: begin
            for (int i = 0; i < NUM_CPUS; i++) begin
               if (cpu_ok && (32'(i) == 32'(item.cpu))) begin
                  online_in[i] = item.online_flag;
               end
            end
         end
         OP_READ_CNT: begin
            if (cpu_ok) begin
               rsp.polled_count  = tbl_rd.polled;
               rsp.handled_count = tbl_rd.handled;
            end
         end
         default: begin
         end
      endcase

      rsp.generation_out  = gen_in;
      rsp.completed_count = completed_in;
   end

   // table changes only on a step
   always_comb begin
      tbl_upd             = upd;
      tbl_upd.ack_en      = upd.ack_en && fire;
      tbl_upd.inc_polled  = upd.inc_polled && fire;
      tbl_upd.inc_handled = upd.inc_handled && fire;
   end

   // request state
   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff       <= '0;
         addr_ff      <= '0;
         in_flight_ff <= 1'b0;
         busy_ff      <= 1'b0;
         init_ff      <= '0;
         elapsed_ff   <= '0;
         online_ff    <= '0;
         completed_ff <= '0;
      end else if (fire) begin
         gen_ff       <= gen_in;
         addr_ff      <= addr_in;
         in_flight_ff <= in_flight_in;
         busy_ff      <= busy_in;
         init_ff      <= init_in;
         elapsed_ff   <= elapsed_in;
         online_ff    <= online_in;
         completed_ff <= completed_in;
      end
   end

endmodule

`default_nettype wire

/* design/tsd_checker.sv */
// ----------------------------------------------------------------------------
// tsd_checker: port-level checks of the shootdown tracker
// Watches the result channel of the top level and is bound to it.
// ----------------------------------------------------------------------------
`default_nettype none

module tsd_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire tsd_pkg::rsp_type rsp_item
);
   import tsd_pkg::*;

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("result changed while stalled");

   // interrupts go out only on a started request
   a_ipi_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.status != ST_STARTED) |-> rsp_item.ipi_mask == 8'd0)
      else $error("interrupt mask outside a start");

   // a lagging cpu is reported only on timeout
   a_stuck_timeout: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.status != ST_TIMEOUT) |-> rsp_item.lagging_cpu == 3'd0)
      else $error("lagging cpu outside a timeout");

   // no invalidation address without invalidation, and started means invalidate
   a_inv_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.invalidate_valid |->
         (rsp_item.invalidate_address == 64'd0) && (rsp_item.status != ST_STARTED))
      else $error("invalidation fields disagree");

endmodule

bind tlb_shootdown_tracker_core tsd_checker u_tsd_checker (
   .clock    (clock),
   .reset    (reset),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_item (rsp_item)
);

`default_nettype wire
